// ===== sv/assert_macros.svh =====
// Assertion shorthands, clocked on clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define STVS_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define STVS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define STVS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/stvs_pkg.sv =====
`default_nettype none

package stvs_pkg;

   localparam int COORD_BITS     = 13;
   localparam int ID_BITS        = 5;
   localparam int REG_BITS       = 13;
   localparam int AXIS_BITS      = COORD_BITS + 1;
   localparam int CMP_BITS       = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RESET = REG_BITS'(1920);
   localparam logic [REG_BITS-1:0] MAX_DELTA_RESET    = REG_BITS'(160);
   localparam logic [REG_BITS-1:0] DEAD_ZONE_RESET    = REG_BITS'(5);

   typedef enum logic [1:0] {
      CMD_DOWN = 2'd0,
      CMD_UP   = 2'd1,
      CMD_MOVE = 2'd2,
      CMD_TICK = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH = 2'd0,
      CSR_MAX_DELTA    = 2'd1,
      CSR_DEAD_ZONE    = 2'd2
   } csr_type;

   typedef struct packed {
      logic [REG_BITS-1:0] max_delta;
      logic [REG_BITS-1:0] dead_zone;
   } shape_cfg_type;

endpackage

`default_nettype wire

// ===== sv/stvs_shape.sv =====
`default_nettype none

// Clamp a stick deflection to +-max_delta, then apply the dead zone.
module stvs_shape (
   input  wire stvs_pkg::shape_cfg_type               cfg,
   input  wire logic signed [stvs_pkg::AXIS_BITS-1:0] diff,
   output logic signed [stvs_pkg::AXIS_BITS-1:0]      axis
);

   logic signed [stvs_pkg::CMP_BITS-1:0] d_w;
   logic signed [stvs_pkg::CMP_BITS-1:0] m_w;
   logic signed [stvs_pkg::CMP_BITS-1:0] z_w;
   logic signed [stvs_pkg::CMP_BITS-1:0] c_w;
   logic signed [stvs_pkg::CMP_BITS-1:0] a_w;
   logic signed [stvs_pkg::CMP_BITS-1:0] r_w;

   assign d_w = stvs_pkg::CMP_BITS'(diff);
   assign m_w = $signed(stvs_pkg::CMP_BITS'(cfg.max_delta));
   assign z_w = $signed(stvs_pkg::CMP_BITS'(cfg.dead_zone));

   always_comb begin
      if (d_w > m_w) begin
         c_w = m_w;
      end else if (d_w < -m_w) begin
         c_w = -m_w;
      end else begin
         c_w = d_w;
      end
      a_w = c_w[stvs_pkg::CMP_BITS-1] ? -c_w : c_w;
      if (a_w < z_w) begin
         r_w = '0;
      end else if (c_w[stvs_pkg::CMP_BITS-1]) begin
         r_w = c_w + z_w;
      end else begin
         r_w = c_w - z_w;
      end
   end

   // magnitude never exceeds |diff|, so the cut is lossless
   assign axis = stvs_pkg::AXIS_BITS'(r_w);

endmodule

`default_nettype wire

// ===== sv/split_touch_virtual_sticks_top.sv =====
`default_nettype none

// Split-screen touch to dual virtual thumbstick converter.
// Request channel (req_*): one touch event per word: cmd (down, up, move,
// tick), pointer id and x/y pixel position. Response channel (rsp_*): one
// word per request with all four axes, both held flags and axes_changed.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Registers screen_width, max_delta and dead_zone are written
// through csr_we/csr_index/csr_wdata (index 0, 1, 2); the user writes them only
// while the block is idle (not enforced by the block). Requests pass the input
// and state registers. Throughput: one word per cycle; the input register takes
// a new word in every cycle in which it is empty or its word moves on to the
// response. When the receiver stalls, the response holds and the input register
// fills, after which req_stall rises until the response is taken. Reset
// (synchronous, active high) frees both sticks, zeroes the axes, empties the
// pipeline and restores the register defaults (1920, 160, 5).
module split_touch_virtual_sticks_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [stvs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [stvs_pkg::REG_BITS-1:0]          csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_cmd,
   input  wire logic [stvs_pkg::ID_BITS-1:0]           req_pointer_id,
   input  wire logic [stvs_pkg::COORD_BITS-1:0]        req_pos_x,
   input  wire logic [stvs_pkg::COORD_BITS-1:0]        req_pos_y,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [stvs_pkg::AXIS_BITS-1:0]       rsp_left_axis_x,
   output logic signed [stvs_pkg::AXIS_BITS-1:0]       rsp_left_axis_y,
   output logic signed [stvs_pkg::AXIS_BITS-1:0]       rsp_right_axis_x,
   output logic signed [stvs_pkg::AXIS_BITS-1:0]       rsp_right_axis_y,
   output logic                                        rsp_left_held,
   output logic                                        rsp_right_held,
   output logic                                        rsp_axes_changed
);

`include "assert_macros.svh"

   localparam int CB = stvs_pkg::COORD_BITS;
   localparam int AB = stvs_pkg::AXIS_BITS;
   localparam int HB = ((CB > stvs_pkg::REG_BITS) ? CB : stvs_pkg::REG_BITS);

   // configuration
   logic [stvs_pkg::REG_BITS-1:0] screen_width_ff;
   logic [stvs_pkg::REG_BITS-1:0] max_delta_ff;
   logic [stvs_pkg::REG_BITS-1:0] dead_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= stvs_pkg::SCREEN_WIDTH_RESET;
         max_delta_ff    <= stvs_pkg::MAX_DELTA_RESET;
         dead_zone_ff    <= stvs_pkg::DEAD_ZONE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            stvs_pkg::CSR_SCREEN_WIDTH: screen_width_ff <= csr_wdata;
            stvs_pkg::CSR_MAX_DELTA:    max_delta_ff    <= csr_wdata;
            stvs_pkg::CSR_DEAD_ZONE:    dead_zone_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic                        s1_valid_ff;
   stvs_pkg::cmd_type           s1_cmd_ff;
   logic [stvs_pkg::ID_BITS-1:0] s1_id_ff;
   logic [CB-1:0]               s1_x_ff;
   logic [CB-1:0]               s1_y_ff;
   logic                        adv;
   logic                        adv_down;
   logic                        rsp_valid_ff;

   assign adv       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign adv_down  = adv && (s1_cmd_ff == stvs_pkg::CMD_DOWN);
   assign req_stall = s1_valid_ff && !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_cmd_ff <= stvs_pkg::cmd_type'(req_cmd);
         s1_id_ff  <= req_pointer_id;
         s1_x_ff   <= req_pos_x;
         s1_y_ff   <= req_pos_y;
      end
   end

   // stick state
   logic                         lv_ff, rv_ff, lv_in, rv_in;
   logic [stvs_pkg::ID_BITS-1:0] lid_ff, rid_ff, lid_in, rid_in;
   logic [CB-1:0] lox_ff, loy_ff, lpx_ff, lpy_ff, rox_ff, roy_ff, rpx_ff, rpy_ff;
   logic [CB-1:0] lox_in, loy_in, lpx_in, lpy_in, rox_in, roy_in, rpx_in, rpy_in;
   logic signed [AB-1:0] lax_ff, lay_ff, rax_ff, ray_ff;
   logic signed [AB-1:0] lax_in, lay_in, rax_in, ray_in;
   logic signed [AB-1:0] lsx, lsy, rsx, rsy;
   logic changed_ff, changed_in;
   logic left_match, right_match, is_left;
   stvs_pkg::shape_cfg_type shape_cfg;

   assign shape_cfg.max_delta = max_delta_ff;
   assign shape_cfg.dead_zone = dead_zone_ff;

   assign left_match  = lv_ff && (lid_ff == s1_id_ff);
   assign right_match = rv_ff && (rid_ff == s1_id_ff);
   assign is_left     = HB'(s1_x_ff) < HB'(screen_width_ff >> 1);

   stvs_shape u_shape_lx (.cfg(shape_cfg),
      .diff($signed({1'b0, lpx_ff}) - $signed({1'b0, lox_ff})), .axis(lsx));
   stvs_shape u_shape_ly (.cfg(shape_cfg),
      .diff($signed({1'b0, lpy_ff}) - $signed({1'b0, loy_ff})), .axis(lsy));
   stvs_shape u_shape_rx (.cfg(shape_cfg),
      .diff($signed({1'b0, rpx_ff}) - $signed({1'b0, rox_ff})), .axis(rsx));
   stvs_shape u_shape_ry (.cfg(shape_cfg),
      .diff($signed({1'b0, rpy_ff}) - $signed({1'b0, roy_ff})), .axis(rsy));

   always_comb begin
      lv_in = lv_ff;   lid_in = lid_ff;
      lox_in = lox_ff; loy_in = loy_ff; lpx_in = lpx_ff; lpy_in = lpy_ff;
      rv_in = rv_ff;   rid_in = rid_ff;
      rox_in = rox_ff; roy_in = roy_ff; rpx_in = rpx_ff; rpy_in = rpy_ff;
      lax_in = lax_ff; lay_in = lay_ff; rax_in = rax_ff; ray_in = ray_ff;
      case (s1_cmd_ff)
         stvs_pkg::CMD_DOWN: begin
            // a down on a held half is dropped
            if (is_left && !lv_ff) begin
               lv_in = 1'b1;     lid_in = s1_id_ff;
               lox_in = s1_x_ff; loy_in = s1_y_ff;
               lpx_in = s1_x_ff; lpy_in = s1_y_ff;
            end else if (!is_left && !rv_ff) begin
               rv_in = 1'b1;     rid_in = s1_id_ff;
               rox_in = s1_x_ff; roy_in = s1_y_ff;
               rpx_in = s1_x_ff; rpy_in = s1_y_ff;
            end
         end
         stvs_pkg::CMD_UP: begin
            // left wins when one finger owns both sticks
            if (left_match) begin
               lv_in = 1'b0; lax_in = '0; lay_in = '0;
               lpx_in = lox_ff; lpy_in = loy_ff;
            end else if (right_match) begin
               rv_in = 1'b0; rax_in = '0; ray_in = '0;
               rpx_in = rox_ff; rpy_in = roy_ff;
            end
         end
         stvs_pkg::CMD_MOVE: begin
            if (left_match) begin
               lpx_in = s1_x_ff; lpy_in = s1_y_ff;
            end else if (right_match) begin
               rpx_in = s1_x_ff; rpy_in = s1_y_ff;
            end
         end
         default: begin
            if (lv_ff) begin
               lax_in = lsx; lay_in = lsy;
            end
            if (rv_ff) begin
               rax_in = rsx; ray_in = rsy;
            end
         end
      endcase
      changed_in = (lax_in != lax_ff) || (lay_in != lay_ff) ||
                   (rax_in != rax_ff) || (ray_in != ray_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff  <= 1'b0;
         rv_ff  <= 1'b0;
         lax_ff <= '0;
         lay_ff <= '0;
         rax_ff <= '0;
         ray_ff <= '0;
      end else if (adv) begin
         lv_ff  <= lv_in;
         rv_ff  <= rv_in;
         lax_ff <= lax_in;
         lay_ff <= lay_in;
         rax_ff <= rax_in;
         ray_ff <= ray_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lid_ff <= lid_in; lox_ff <= lox_in; loy_ff <= loy_in;
         lpx_ff <= lpx_in; lpy_ff <= lpy_in;
         rid_ff <= rid_in; rox_ff <= rox_in; roy_ff <= roy_in;
         rpx_ff <= rpx_in; rpy_ff <= rpy_in;
         changed_ff <= changed_in;
      end
   end

   // response register; state only moves on adv, which needs a free slot,
   // so the axis and held registers double as the response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_axis_x  = lax_ff;
   assign rsp_left_axis_y  = lay_ff;
   assign rsp_right_axis_x = rax_ff;
   assign rsp_right_axis_y = ray_ff;
   assign rsp_left_held    = lv_ff;
   assign rsp_right_held   = rv_ff;
   assign rsp_axes_changed = changed_ff;

   `STVS_ASSERT_IMPL(a_left_free_zero, !lv_ff, {lax_ff, lay_ff} == '0, "free left stick moved")
   `STVS_ASSERT_IMPL(a_right_free_zero, !rv_ff, {rax_ff, ray_ff} == '0, "free right stick moved")
   `STVS_ASSERT_NEXT(a_adv_rsp, adv, rsp_valid_ff, "advanced word missing on response")
   `STVS_ASSERT_IMPL(a_left_claim, $rose(lv_ff), $past(adv_down), "left claimed without a down")

endmodule

`default_nettype wire

// ===== sim/tb_split_touch_virtual_sticks_top.sv =====
`timescale 1ns / 100ps

module tb_split_touch_virtual_sticks_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NO_STICK       = -1;
   localparam int CB             = stvs_pkg::COORD_BITS;
   localparam int IB             = stvs_pkg::ID_BITS;
   localparam int AB             = stvs_pkg::AXIS_BITS;
   localparam int COORD_MAX      = (1 << CB) - 1;

   // Tracks both sticks and holds the reports the block owes us, oldest first.
   class stick_tracker;
      typedef struct {
         bit            held;
         logic [IB-1:0] owner;
         int            ox, oy, px, py;
      } stick_state;

      typedef struct {
         int axis[4];
         bit left_held, right_held, changed;
      } stick_report;

      int          screen_width, max_delta, dead_zone;
      stick_state  sticks[2];
      int          axis[4];
      stick_report pending_reports[$];
      int          errors;

      function new();
         screen_width = stvs_pkg::SCREEN_WIDTH_RESET;
         max_delta    = stvs_pkg::MAX_DELTA_RESET;
         dead_zone    = stvs_pkg::DEAD_ZONE_RESET;
         for (int s = 0; s < 2; s++) begin
            sticks[s] = '{held: 1'b0, owner: '0, ox: 0, oy: 0, px: 0, py: 0};
         end
         for (int i = 0; i < 4; i++) axis[i] = 0;
         errors = 0;
      endfunction

      function void set_reg(stvs_pkg::csr_type idx, int value);
         case (idx)
            stvs_pkg::CSR_SCREEN_WIDTH: screen_width = value;
            stvs_pkg::CSR_MAX_DELTA:    max_delta = value;
            stvs_pkg::CSR_DEAD_ZONE:    dead_zone = value;
            default: ;
         endcase
      endfunction

      function int shape_deflection(int d);
         int a;
         if (d > max_delta) d = max_delta;
         if (d < -max_delta) d = -max_delta;
         a = (d < 0) ? -d : d;
         if (a < dead_zone) return 0;
         return (d < 0) ? d + dead_zone : d - dead_zone;
      endfunction

      // left stick wins when one finger owns both
      function int owner_of(logic [IB-1:0] id);
         for (int s = 0; s < 2; s++) begin
            if (sticks[s].held && sticks[s].owner == id) return s;
         end
         return NO_STICK;
      endfunction

      function void note_event(stvs_pkg::cmd_type cmd, logic [IB-1:0] id,
                               logic [CB-1:0] x, logic [CB-1:0] y);
         int          prior[4];
         int          s;
         stick_report r;
         for (int i = 0; i < 4; i++) prior[i] = axis[i];
         case (cmd)
            stvs_pkg::CMD_DOWN: begin
               s = (int'(x) < (screen_width >> 1)) ? 0 : 1;
               if (!sticks[s].held) begin
                  sticks[s].held  = 1'b1;
                  sticks[s].owner = id;
                  sticks[s].ox = x;
                  sticks[s].oy = y;
                  sticks[s].px = x;
                  sticks[s].py = y;
               end
            end
            stvs_pkg::CMD_UP: begin
               s = owner_of(id);
               if (s != NO_STICK) begin
                  sticks[s].held = 1'b0;
                  axis[2*s]      = 0;
                  axis[2*s+1]    = 0;
                  sticks[s].px   = sticks[s].ox;
                  sticks[s].py   = sticks[s].oy;
               end
            end
            stvs_pkg::CMD_MOVE: begin
               s = owner_of(id);
               if (s != NO_STICK) begin
                  sticks[s].px = x;
                  sticks[s].py = y;
               end
            end
            default: begin
               for (int k = 0; k < 2; k++) begin
                  if (sticks[k].held) begin
                     axis[2*k]   = shape_deflection(sticks[k].px - sticks[k].ox);
                     axis[2*k+1] = shape_deflection(sticks[k].py - sticks[k].oy);
                  end
               end
            end
         endcase
         r.changed = 1'b0;
         for (int i = 0; i < 4; i++) begin
            r.axis[i] = axis[i];
            if (axis[i] != prior[i]) r.changed = 1'b1;
         end
         r.left_held  = sticks[0].held;
         r.right_held = sticks[1].held;
         pending_reports.push_back(r);
      endfunction

      function void check_field(string name, int exp, logic signed [AB-1:0] act);
         logic signed [AB-1:0] want;
         want = AB'(exp);
         if (act !== want) begin
            $error("%s: expected %0d, got %0d", name, want, act);
            errors++;
         end
      endfunction

      function void check_report(logic signed [AB-1:0] lx, logic signed [AB-1:0] ly,
                                 logic signed [AB-1:0] rx, logic signed [AB-1:0] ry,
                                 logic lh, logic rh, logic ch);
         stick_report r;
         if (pending_reports.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         r = pending_reports.pop_front();
         check_field("left_axis_x", r.axis[0], lx);
         check_field("left_axis_y", r.axis[1], ly);
         check_field("right_axis_x", r.axis[2], rx);
         check_field("right_axis_y", r.axis[3], ry);
         check_field("left_held", r.left_held, lh);
         check_field("right_held", r.right_held, rh);
         check_field("axes_changed", r.changed, ch);
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction
   endclass

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    csr_we = 1'b0;
   logic [stvs_pkg::CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [stvs_pkg::REG_BITS-1:0]           csr_wdata = '0;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic [1:0]                              req_cmd = '0;
   logic [IB-1:0]                           req_pointer_id = '0;
   logic [CB-1:0]                           req_pos_x = '0;
   logic [CB-1:0]                           req_pos_y = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic signed [AB-1:0]                    rsp_left_axis_x, rsp_left_axis_y;
   logic signed [AB-1:0]                    rsp_right_axis_x, rsp_right_axis_y;
   logic                                    rsp_left_held, rsp_right_held, rsp_axes_changed;

   stick_tracker tracker = new();

   // last touch-down point per finger, so moves land near the origin
   logic [CB-1:0] touch_x[32];
   logic [CB-1:0] touch_y[32];

   typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             idle_cycles = 0;

   split_touch_virtual_sticks_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pointer_id   (req_pointer_id),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_axis_x  (rsp_left_axis_x),
      .rsp_left_axis_y  (rsp_left_axis_y),
      .rsp_right_axis_x (rsp_right_axis_x),
      .rsp_right_axis_y (rsp_right_axis_y),
      .rsp_left_held    (rsp_left_held),
      .rsp_right_held   (rsp_right_held),
      .rsp_axes_changed (rsp_axes_changed)
   );

   always #2 clock = ~clock;

   // receiver stall pattern, switching among four modes at random
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_stall <= (stall_left % 4 == 0);
         default:        rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_report(rsp_left_axis_x, rsp_left_axis_y, rsp_right_axis_x,
                              rsp_right_axis_y, rsp_left_held, rsp_right_held,
                              rsp_axes_changed);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(input stvs_pkg::cmd_type cmd, input logic [IB-1:0] id,
                            input logic [CB-1:0] x, input logic [CB-1:0] y);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_pointer_id <= id;
      req_pos_x      <= x;
      req_pos_y      <= y;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.note_event(cmd, id, x, y);
   endtask

   task automatic idle_req(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input stvs_pkg::csr_type idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= stvs_pkg::REG_BITS'(value);
      tracker.set_reg(idx, value);
   endtask

   task automatic set_config(input int width, input int max_d, input int dead);
      drain_responses();
      write_reg(stvs_pkg::CSR_SCREEN_WIDTH, width);
      write_reg(stvs_pkg::CSR_MAX_DELTA, max_d);
      write_reg(stvs_pkg::CSR_DEAD_ZONE, dead);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CB-1:0] near_coord(input int base, input int span);
      int v;
      v = base + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return CB'(v);
   endfunction

   // mostly down/move/tick/up on a small pool of fingers, with stray ids mixed in
   task automatic random_phase(input int n_items);
      logic [IB-1:0]     ids[3];
      logic [IB-1:0]     id;
      logic [CB-1:0]     x, y;
      stvs_pkg::cmd_type cmd;
      int                burst, pick, span;
      for (int k = 0; k < 3; k++) ids[k] = IB'($urandom_range(0, 31));
      span = tracker.max_delta + tracker.dead_zone + 4;
      if (span > COORD_MAX) span = COORD_MAX;
      burst = 0;
      for (int n = 0; n < n_items; n++) begin
         if (burst == 0) begin
            idle_req($urandom_range(1, 12));
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 15);
         end
         burst--;
         id   = ($urandom_range(0, 9) == 0) ? IB'($urandom) : ids[$urandom_range(0, 2)];
         x    = CB'($urandom);
         y    = CB'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            cmd = stvs_pkg::CMD_DOWN;
            if ($urandom_range(0, 2) == 0) x = near_coord(tracker.screen_width >> 1, 2);
            touch_x[id] = x;
            touch_y[id] = y;
         end else if (pick < 57) begin
            cmd = stvs_pkg::CMD_MOVE;
            if ($urandom_range(0, 4) != 0) begin
               x = near_coord(touch_x[id], span);
               y = near_coord(touch_y[id], span);
            end
         end else if (pick < 70) begin
            cmd = stvs_pkg::CMD_UP;
         end else begin
            cmd = stvs_pkg::CMD_TICK;
         end
         send_word(cmd, id, x, y);
      end
   endtask

   initial begin
      for (int i = 0; i < 32; i++) begin
         touch_x[i] = '0;
         touch_y[i] = '0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: default registers, split at x = 960
      send_word(stvs_pkg::CMD_TICK, 5'd0, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_DOWN, 5'd3, 13'd100, 13'd200);
      send_word(stvs_pkg::CMD_DOWN, 5'd4, 13'd1000, 13'd500);
      send_word(stvs_pkg::CMD_DOWN, 5'd7, 13'd10, 13'd10);       // left already owned
      send_word(stvs_pkg::CMD_DOWN, 5'd8, 13'd959, 13'd8191);    // left already owned
      send_word(stvs_pkg::CMD_MOVE, 5'd3, 13'd300, 13'd100);
      send_word(stvs_pkg::CMD_MOVE, 5'd4, 13'd1003, 13'd500);    // inside dead zone
      send_word(stvs_pkg::CMD_TICK, 5'd0, 13'd8191, 13'd8191);
      send_word(stvs_pkg::CMD_TICK, 5'd1, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_UP, 5'd9, 13'd0, 13'd0);           // unknown finger
      send_word(stvs_pkg::CMD_MOVE, 5'd9, 13'd8191, 13'd8191);   // unknown finger
      send_word(stvs_pkg::CMD_UP, 5'd3, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_TICK, 5'd0, 13'd0, 13'd0);         // left free keeps zeros
      send_word(stvs_pkg::CMD_UP, 5'd4, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_DOWN, 5'd5, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_DOWN, 5'd5, 13'd960, 13'd8191);    // same finger on both sticks
      send_word(stvs_pkg::CMD_MOVE, 5'd5, 13'd8191, 13'd8191);
      send_word(stvs_pkg::CMD_TICK, 5'd0, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_UP, 5'd5, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_MOVE, 5'd5, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_TICK, 5'd0, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_UP, 5'd5, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_DOWN, 5'd31, 13'd8191, 13'd0);
      send_word(stvs_pkg::CMD_MOVE, 5'd31, 13'd0, 13'd8191);
      send_word(stvs_pkg::CMD_TICK, 5'd31, 13'd0, 13'd0);
      send_word(stvs_pkg::CMD_UP, 5'd31, 13'd0, 13'd0);

      random_phase(160);
      set_config(8191, 8191, 0);
      random_phase(170);
      set_config(0, 0, 8191);
      random_phase(120);
      set_config(1000, 50, 100);                       // dead zone past the clamp
      random_phase(170);
      set_config($urandom_range(0, 8191), $urandom_range(0, 400), $urandom_range(0, 40));
      random_phase(170);
      set_config(4, 1, 1);
      random_phase(170);

      drain_responses();
      repeat (8) @(negedge clock);
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/stvs_pkg.sv
sv/stvs_shape.sv
sv/split_touch_virtual_sticks_top.sv
sim/tb_split_touch_virtual_sticks_top.sv
